[sv/pic_pkg.sv]
// ----------------------------------------------------------------------------
// pic_pkg
// Shared widths, types and codes for the point-in-capsule test pipeline.
// ----------------------------------------------------------------------------
package pic_pkg;

  // coordinate format, signed fixed point
  localparam int COORD_BITS   = 32;
  localparam int RAD_BITS     = COORD_BITS - 1;
  localparam int CFG_IDX_BITS = 3;

  // arithmetic widths, all derived from the coordinate width
  localparam int DIFF_BITS  = COORD_BITS + 1;
  localparam int PROD_BITS  = 2 * DIFF_BITS;
  localparam int CROSS_BITS = PROD_BITS + 1;
  localparam int DOT_BITS   = PROD_BITS + 2;
  localparam int MUL_BITS   = PROD_BITS;
  localparam int RSQ_BITS   = 2 * RAD_BITS;
  localparam int WIDE_BITS  = 2 * MUL_BITS;
  localparam int LHS_BITS   = WIDE_BITS + 2;

  // limb split of the wide multipliers
  localparam int MUL_LIMBS = 3;
  localparam int LIMB_BITS = (MUL_BITS + MUL_LIMBS - 1) / MUL_LIMBS;
  localparam int PAD_BITS  = LIMB_BITS * MUL_LIMBS;
  localparam int PP_BITS   = 2 * LIMB_BITS;
  localparam int ROW_BITS  = PP_BITS + LIMB_BITS * (MUL_LIMBS - 1) + 2;

  // pipeline stage positions
  localparam int STG_DIFF   = 0;
  localparam int STG_PROD   = 1;
  localparam int STG_SUM    = 2;
  localparam int STG_PART   = 3;
  localparam int STG_ROW    = 4;
  localparam int STG_WIDE   = 5;
  localparam int STG_LHS    = 6;
  localparam int STG_OUT    = 7;
  localparam int NUM_STAGES = 8;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic        [RAD_BITS-1:0]   rad_t;
  typedef logic signed [DIFF_BITS-1:0]  diff_t;
  typedef logic signed [PROD_BITS-1:0]  prod_t;
  typedef logic signed [CROSS_BITS-1:0] cross_t;
  typedef logic signed [DOT_BITS-1:0]   dot_t;
  typedef logic        [MUL_BITS-1:0]   mul_t;
  typedef logic        [RSQ_BITS-1:0]   rsq_t;
  typedef logic        [WIDE_BITS-1:0]  wide_t;
  typedef logic        [LHS_BITS-1:0]   lhs_t;
  typedef logic        [PP_BITS-1:0]    pp_t;
  typedef logic        [ROW_BITS-1:0]   row_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_START_X = 3'd0,
    CFG_START_Y = 3'd1,
    CFG_START_Z = 3'd2,
    CFG_END_X   = 3'd3,
    CFG_END_Y   = 3'd4,
    CFG_END_Z   = 3'd5,
    CFG_RADIUS  = 3'd6
  } cfg_idx_e;

  typedef enum logic [1:0] {
    REG_BEFORE = 2'd0,
    REG_ALONG  = 2'd1,
    REG_BEYOND = 2'd2
  } region_e;

  // per-stage load enables and occupancy
  typedef struct packed {
    logic [NUM_STAGES-1:0] load;
    logic [NUM_STAGES-1:0] valid;
  } pipe_ctl_t;

  // dot products and magnitudes handed from the front to the back half
  typedef struct packed {
    mul_t             len2;
    dot_t             dotp;
    mul_t             vv;
    mul_t             ww;
    mul_t [2:0]       cmag;
    mul_t             rsq;
  } front_res_t;

endpackage

[sv/pic_ctrl.sv]
// ----------------------------------------------------------------------------
// pic_ctrl
// Valid bits of the pipeline and per-stage load enables with bubble removal.
// ----------------------------------------------------------------------------
module pic_ctrl
  import pic_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output pipe_ctl_t ctl_o
);

  logic [NUM_STAGES-1:0] valid_q, valid_d;
  logic [NUM_STAGES-1:0] load;

  // a stage loads when it is empty or its content moves on
  always_comb begin
    load[NUM_STAGES-1] = !valid_q[NUM_STAGES-1] || out_ready_i;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      load[k] = !valid_q[k] || load[k+1];
    end
  end

  always_comb begin
    valid_d[0] = load[0] ? in_valid_i : valid_q[0];
    for (int k = 1; k < NUM_STAGES; k++) begin
      valid_d[k] = load[k] ? valid_q[k-1] : valid_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign in_ready_o  = load[0];
  assign out_valid_o = valid_q[NUM_STAGES-1];
  assign ctl_o.load  = load;
  assign ctl_o.valid = valid_q;

endmodule

[sv/pic_front.sv]
// ----------------------------------------------------------------------------
// pic_front
// Differences, narrow products and dot-product sums (first three stages).
// ----------------------------------------------------------------------------
module pic_front
  import pic_pkg::*;
(
  input  logic       clk_i,
  input  pipe_ctl_t  ctl_i,
  input  coord_t     point_i     [3],
  input  coord_t     seg_start_i [3],
  input  coord_t     seg_end_i   [3],
  input  rad_t       radius_i,
  output front_res_t res_o
);

  diff_t  n_c   [3];
  diff_t  v_d   [3];
  diff_t  w_d   [3];
  diff_t  v_q   [3];
  diff_t  w_q   [3];

  prod_t  nn_q  [3];
  prod_t  nv_q  [3];
  prod_t  vsq_q [3];
  prod_t  wsq_q [3];
  prod_t  cra_q [3];
  prod_t  crb_q [3];
  rsq_t   rsq_q;

  cross_t cdiff_ab [3];
  cross_t cdiff_ba [3];
  dot_t   len_sum, dot_sum, vv_sum, ww_sum;

  front_res_t res_d, res_q;

  // segment direction straight from the registers
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      n_c[i] = diff_t'(seg_end_i[i]) - diff_t'(seg_start_i[i]);
      v_d[i] = diff_t'(point_i[i]) - diff_t'(seg_start_i[i]);
      w_d[i] = diff_t'(point_i[i]) - diff_t'(seg_end_i[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load[STG_DIFF]) begin
      v_q <= v_d;
      w_q <= w_d;
    end
  end

  // one signed product per term, registered
  always_ff @(posedge clk_i) begin
    if (ctl_i.load[STG_PROD]) begin
      for (int i = 0; i < 3; i++) begin
        nn_q[i]  <= prod_t'(n_c[i]) * prod_t'(n_c[i]);
        nv_q[i]  <= prod_t'(n_c[i]) * prod_t'(v_q[i]);
        vsq_q[i] <= prod_t'(v_q[i]) * prod_t'(v_q[i]);
        wsq_q[i] <= prod_t'(w_q[i]) * prod_t'(w_q[i]);
      end
      // cross product n x v, two terms per component
      cra_q[0] <= prod_t'(n_c[1]) * prod_t'(v_q[2]);
      crb_q[0] <= prod_t'(n_c[2]) * prod_t'(v_q[1]);
      cra_q[1] <= prod_t'(n_c[2]) * prod_t'(v_q[0]);
      crb_q[1] <= prod_t'(n_c[0]) * prod_t'(v_q[2]);
      cra_q[2] <= prod_t'(n_c[0]) * prod_t'(v_q[1]);
      crb_q[2] <= prod_t'(n_c[1]) * prod_t'(v_q[0]);
      rsq_q    <= rsq_t'(radius_i) * rsq_t'(radius_i);
    end
  end

  always_comb begin
    len_sum = dot_t'(nn_q[0]) + dot_t'(nn_q[1]) + dot_t'(nn_q[2]);
    dot_sum = dot_t'(nv_q[0]) + dot_t'(nv_q[1]) + dot_t'(nv_q[2]);
    vv_sum  = dot_t'(vsq_q[0]) + dot_t'(vsq_q[1]) + dot_t'(vsq_q[2]);
    ww_sum  = dot_t'(wsq_q[0]) + dot_t'(wsq_q[1]) + dot_t'(wsq_q[2]);
    for (int i = 0; i < 3; i++) begin
      cdiff_ab[i] = cross_t'(cra_q[i]) - cross_t'(crb_q[i]);
      cdiff_ba[i] = cross_t'(crb_q[i]) - cross_t'(cra_q[i]);
    end
    res_d.len2 = len_sum[MUL_BITS-1:0];
    res_d.dotp = dot_sum;
    res_d.vv   = vv_sum[MUL_BITS-1:0];
    res_d.ww   = ww_sum[MUL_BITS-1:0];
    // magnitude picks whichever difference is non-negative
    for (int i = 0; i < 3; i++) begin
      res_d.cmag[i] = cdiff_ab[i][CROSS_BITS-1] ? cdiff_ba[i][MUL_BITS-1:0]
                                                : cdiff_ab[i][MUL_BITS-1:0];
    end
    res_d.rsq  = mul_t'(rsq_q);
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load[STG_SUM]) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

[sv/pic_wide_mul.sv]
// ----------------------------------------------------------------------------
// pic_wide_mul
// Unsigned wide multiplier split into limbs over three register stages.
// ----------------------------------------------------------------------------
module pic_wide_mul
  import pic_pkg::*;
(
  input  logic      clk_i,
  input  pipe_ctl_t ctl_i,
  input  mul_t      a_i,
  input  mul_t      b_i,
  output wide_t     prod_o
);

  logic [PAD_BITS-1:0] a_pad, b_pad;
  pp_t   pp_d  [MUL_LIMBS][MUL_LIMBS];
  pp_t   pp_q  [MUL_LIMBS][MUL_LIMBS];
  row_t  row_d [MUL_LIMBS];
  row_t  row_q [MUL_LIMBS];
  wide_t prod_d, prod_q;

  assign a_pad = PAD_BITS'(a_i);
  assign b_pad = PAD_BITS'(b_i);

  always_comb begin
    for (int i = 0; i < MUL_LIMBS; i++) begin
      for (int j = 0; j < MUL_LIMBS; j++) begin
        pp_d[i][j] = pp_t'(a_pad[i*LIMB_BITS +: LIMB_BITS])
                   * pp_t'(b_pad[j*LIMB_BITS +: LIMB_BITS]);
      end
    end
  end

  // one row per limb of a
  always_comb begin
    for (int i = 0; i < MUL_LIMBS; i++) begin
      row_d[i] = '0;
      for (int j = 0; j < MUL_LIMBS; j++) begin
        row_d[i] = row_d[i] + (row_t'(pp_q[i][j]) << (j * LIMB_BITS));
      end
    end
  end

  always_comb begin
    prod_d = '0;
    for (int i = 0; i < MUL_LIMBS; i++) begin
      prod_d = prod_d + (wide_t'(row_q[i]) << (i * LIMB_BITS));
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load[STG_PART]) begin
      pp_q <= pp_d;
    end
    if (ctl_i.load[STG_ROW]) begin
      row_q <= row_d;
    end
    if (ctl_i.load[STG_WIDE]) begin
      prod_q <= prod_d;
    end
  end

  assign prod_o = prod_q;

endmodule

[sv/pic_back.sv]
// ----------------------------------------------------------------------------
// pic_back
// Region decision, wide perpendicular test and the output register.
// ----------------------------------------------------------------------------
module pic_back
  import pic_pkg::*;
(
  input  logic       clk_i,
  input  pipe_ctl_t  ctl_i,
  input  front_res_t front_i,
  output logic       inside_o,
  output logic [1:0] region_o
);

  typedef struct packed {
    region_e region;
    logic    end_in;
  } flag_t;

  flag_t flag_d, flag_part_q, flag_row_q, flag_wide_q, flag_lhs_q;
  logic  zero_len, d_neg, d_gt, near_in, far_in;

  wide_t sq_prod [3];
  wide_t rl_prod;
  lhs_t  lhs_q;
  wide_t rhs_q;
  logic  inside_q;
  region_e region_q;

  always_comb begin
    zero_len = (front_i.len2 == '0);
    d_neg    = front_i.dotp[DOT_BITS-1];
    d_gt     = $signed(front_i.dotp) > $signed(dot_t'(front_i.len2));
    near_in  = (front_i.vv <= front_i.rsq);
    far_in   = (front_i.ww <= front_i.rsq);
  end

  always_comb begin
    priority if (zero_len || d_neg) begin
      flag_d.region = REG_BEFORE;
      flag_d.end_in = near_in;
    end else if (d_gt) begin
      flag_d.region = REG_BEYOND;
      flag_d.end_in = far_in;
    end else begin
      flag_d.region = REG_ALONG;
      flag_d.end_in = near_in;
    end
  end

  // |n x v|^2 equals |v|^2 |n|^2 - (n.v)^2
  for (genvar i = 0; i < 3; i++) begin : g_sq
    pic_wide_mul u_sq (
      .clk_i  (clk_i),
      .ctl_i  (ctl_i),
      .a_i    (front_i.cmag[i]),
      .b_i    (front_i.cmag[i]),
      .prod_o (sq_prod[i])
    );
  end

  pic_wide_mul u_rl (
    .clk_i  (clk_i),
    .ctl_i  (ctl_i),
    .a_i    (front_i.rsq),
    .b_i    (front_i.len2),
    .prod_o (rl_prod)
  );

  always_ff @(posedge clk_i) begin
    if (ctl_i.load[STG_PART]) begin
      flag_part_q <= flag_d;
    end
    if (ctl_i.load[STG_ROW]) begin
      flag_row_q <= flag_part_q;
    end
    if (ctl_i.load[STG_WIDE]) begin
      flag_wide_q <= flag_row_q;
    end
    if (ctl_i.load[STG_LHS]) begin
      flag_lhs_q <= flag_wide_q;
      lhs_q      <= lhs_t'(sq_prod[0]) + lhs_t'(sq_prod[1]) + lhs_t'(sq_prod[2]);
      rhs_q      <= rl_prod;
    end
    if (ctl_i.load[STG_OUT]) begin
      region_q <= flag_lhs_q.region;
      inside_q <= (flag_lhs_q.region == REG_ALONG) ? (lhs_q <= lhs_t'(rhs_q))
                                                   : flag_lhs_q.end_in;
    end
  end

  assign inside_o = inside_q;
  assign region_o = region_q;

endmodule

[sv/point_in_capsule_test_unit.sv]
// ----------------------------------------------------------------------------
// point_in_capsule_test_unit
// Tests 3-D points against a capsule around a configured segment.
// ----------------------------------------------------------------------------
// One point request is taken per clock unless every stage is full and the output
// is held; it passes through the eight-stage pipeline (differences, narrow
// products, dot sums, region decision with limb partial products, limb rows,
// wide products, perpendicular sum, output register). The point is projected
// onto the segment: before the start it is measured against the start, past
// the end against the end, otherwise against the line, using exact squared
// distances (the perpendicular case as |n x v|^2 <= r^2 |n|^2), so there is
// no rounding. A zero-length segment behaves as a sphere at the start. Each
// stage holds its own valid bit and drains into an empty slot, so a stalled
// output does not block input while a bubble remains. Segment and radius
// registers must only be written while no request is in flight.
module point_in_capsule_test_unit
  import pic_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // configuration write port
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0] cfg_idx_i,
  input  logic [COORD_BITS-1:0]   cfg_data_i,
  // point requests
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  coord_t                  point_x_i,
  input  coord_t                  point_y_i,
  input  coord_t                  point_z_i,
  // results
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic                    inside_res_o,
  output logic [1:0]              region_o
);

  // segment endpoints and radius, reset to zero
  coord_t seg_start_q [3];
  coord_t seg_end_q   [3];
  rad_t   radius_q;

  coord_t     point [3];
  pipe_ctl_t  ctl;
  front_res_t front_res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        seg_start_q[i] <= '0;
        seg_end_q[i]   <= '0;
      end
      radius_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_START_X: seg_start_q[0] <= cfg_data_i;
        CFG_START_Y: seg_start_q[1] <= cfg_data_i;
        CFG_START_Z: seg_start_q[2] <= cfg_data_i;
        CFG_END_X:   seg_end_q[0]   <= cfg_data_i;
        CFG_END_Y:   seg_end_q[1]   <= cfg_data_i;
        CFG_END_Z:   seg_end_q[2]   <= cfg_data_i;
        CFG_RADIUS:  radius_q       <= cfg_data_i[RAD_BITS-1:0];
        default: ; // unused index, write dropped
      endcase
    end
  end

  assign point[0] = point_x_i;
  assign point[1] = point_y_i;
  assign point[2] = point_z_i;

  // occupancy and stall handling
  pic_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .ctl_o       (ctl)
  );

  // stages for differences, products and dot sums
  pic_front u_front (
    .clk_i       (clk_i),
    .ctl_i       (ctl),
    .point_i     (point),
    .seg_start_i (seg_start_q),
    .seg_end_i   (seg_end_q),
    .radius_i    (radius_q),
    .res_o       (front_res)
  );

  // region pick, wide products and output register
  pic_back u_back (
    .clk_i    (clk_i),
    .ctl_i    (ctl),
    .front_i  (front_res),
    .inside_o (inside_res_o),
    .region_o (region_o)
  );

  // any empty stage means a new request can be taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl.valid != {NUM_STAGES{1'b1}}) |-> in_ready_o)
    else $error("pipeline has a bubble but refuses a request");

  // backpressure only when every stage is full and the output is held
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> ((ctl.valid == {NUM_STAGES{1'b1}}) && !out_ready_i))
    else $error("input stalled without a full pipeline");

  // a result only appears when the stage before held one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(ctl.valid[STG_LHS]))
    else $error("result appeared from an empty stage");

endmodule
